// File: rtl/apr_pkg.sv
// Shared types and constants for the converter register block.
// No dependencies; imported by apr_channels, apr_ctrl and the top level.
package apr_pkg;

   // default parameter values
   localparam int NUM_CHANNELS_DEF    = 16;
   localparam int SAMPLE_BITS_DEF     = 10;
   localparam int MAX_TICK_CYCLES_DEF = 255;

   // field widths
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int CHAN_W     = 8;
   localparam int SAMPLE_W   = 10;
   localparam int TICK_W     = 8;
   localparam int VEC_W      = 6;
   localparam int CD_W       = 11;
   localparam int CH_SEL_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PS_W       = 3;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_READ   = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_ADDR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MUX_ADDR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ADDR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ADDR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_VECTOR   = 3'd4;

   // configuration reset values
   localparam logic [ADDR_W-1:0] CONTROL_ADDR_RST = 16'd122;
   localparam logic [ADDR_W-1:0] MUX_ADDR_RST     = 16'd124;
   localparam logic [ADDR_W-1:0] HIGH_ADDR_RST    = 16'd121;
   localparam logic [ADDR_W-1:0] LOW_ADDR_RST     = 16'd120;
   localparam logic [VEC_W-1:0]  IRQ_VECTOR_RST   = 6'd21;

   // control/status and select bit positions
   localparam int BIT_ENABLE = 7;
   localparam int BIT_START  = 6;
   localparam int BIT_LEFT   = 5;
   localparam int BIT_FLAG   = 4;
   localparam int BIT_IRQ_EN = 3;

   localparam logic [CD_W-1:0] CONV_CYCLES = 11'd13;

   typedef struct packed {
      logic                en;
      logic [CH_SEL_W-1:0] idx;
      logic [SAMPLE_W-1:0] data;
   } chan_wr_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_request;
      logic [VEC_W-1:0]  irq_vector;
   } rsp_type;

endpackage

// File: rtl/apr_channels.sv
// Analog channel value bank: one flop row per channel, one write, one read.
// Depends on apr_pkg.
module apr_channels #(
   parameter int NUM_CHANNELS = apr_pkg::NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = apr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  apr_pkg::chan_wr_type            wr_in,
   input  logic [apr_pkg::CH_SEL_W-1:0]    rd_sel,
   output logic [SAMPLE_BITS-1:0]          rd_data
);
   import apr_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CH_SEL_W:0] NUM_CH = (CH_SEL_W + 1)'(NUM_CHANNELS);

   logic [SAMPLE_BITS-1:0] values_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            values_ff[i] <= '0;
         end
      end else if (wr_in.en) begin
         values_ff[wr_in.idx[IDX_W-1:0]] <= wr_in.data[SAMPLE_BITS-1:0];
      end
   end

   // unpopulated channel reads zero
   assign rd_data = ({1'b0, rd_sel} < NUM_CH) ? values_ff[rd_sel[IDX_W-1:0]] : '0;

endmodule

// File: rtl/apr_ctrl.sv
// Register file, conversion countdown and per-request result logic.
// Depends on apr_pkg and apr_channels.
module apr_ctrl #(
   parameter int NUM_CHANNELS    = apr_pkg::NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS     = apr_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_TICK_CYCLES = apr_pkg::MAX_TICK_CYCLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [1:0]                        action,
   input  logic [apr_pkg::ADDR_W-1:0]        bus_address,
   input  logic [apr_pkg::DATA_W-1:0]        write_data,
   input  logic [apr_pkg::CHAN_W-1:0]        channel,
   input  logic [apr_pkg::SAMPLE_W-1:0]      sample_value,
   input  logic [apr_pkg::TICK_W-1:0]        tick_cycles,
   input  logic                              interrupt_accept,
   input  logic                              csr_write_en,
   input  logic [apr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [apr_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output apr_pkg::rsp_type                  result
);
   import apr_pkg::*;

   localparam int MAX_T_CLIP = (MAX_TICK_CYCLES < 255) ? MAX_TICK_CYCLES : 255;
   localparam logic [TICK_W-1:0] MAX_T = TICK_W'(MAX_T_CLIP);
   localparam logic [CHAN_W-1:0] NUM_CH = CHAN_W'(NUM_CHANNELS);
   localparam int LEFT_SHIFT = 16 - SAMPLE_BITS;

   // configuration
   logic [ADDR_W-1:0] control_addr_ff, mux_addr_ff, high_addr_ff, low_addr_ff;
   logic [VEC_W-1:0]  irq_vector_ff;

   // block state
   logic [DATA_W-1:0]      control_ff, control_in;
   logic [DATA_W-1:0]      mux_ff, mux_in;
   logic [CD_W-1:0]        countdown_ff, countdown_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;

   chan_wr_type            chan_wr;
   logic [SAMPLE_BITS-1:0] chan_rd;
   logic [TICK_W-1:0]      cycles;
   logic [PS_W-1:0]        prescale;
   logic [15:0]            adjusted;
   logic [DATA_W-1:0]      cs_tick;

   apr_channels #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_channels (
      .clock  (clock),
      .reset  (reset),
      .wr_in  (chan_wr),
      .rd_sel (mux_ff[CH_SEL_W-1:0]),
      .rd_data(chan_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         control_addr_ff <= CONTROL_ADDR_RST;
         mux_addr_ff     <= MUX_ADDR_RST;
         high_addr_ff    <= HIGH_ADDR_RST;
         low_addr_ff     <= LOW_ADDR_RST;
         irq_vector_ff   <= IRQ_VECTOR_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CONTROL_ADDR: control_addr_ff <= csr_write_data[ADDR_W-1:0];
            CSR_MUX_ADDR:     mux_addr_ff     <= csr_write_data[ADDR_W-1:0];
            CSR_HIGH_ADDR:    high_addr_ff    <= csr_write_data[ADDR_W-1:0];
            CSR_LOW_ADDR:     low_addr_ff     <= csr_write_data[ADDR_W-1:0];
            CSR_IRQ_VECTOR:   irq_vector_ff   <= csr_write_data[VEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= '0;
         mux_ff       <= '0;
         countdown_ff <= '0;
         sample_ff    <= '0;
      end else if (fire) begin
         control_ff   <= control_in;
         mux_ff       <= mux_in;
         countdown_ff <= countdown_in;
         sample_ff    <= sample_in;
      end
   end

   // zero acts as one, long ticks saturate
   always_comb begin
      cycles = (tick_cycles == '0) ? TICK_W'(1) : tick_cycles;
      if (cycles > MAX_T) begin
         cycles = MAX_T;
      end
   end

   assign prescale = (write_data[PS_W-1:0] == '0) ? PS_W'(1) : write_data[PS_W-1:0];
   assign adjusted = mux_ff[BIT_LEFT] ? (16'(sample_ff) << LEFT_SHIFT) : 16'(sample_ff);

   always_comb begin
      control_in   = control_ff;
      mux_in       = mux_ff;
      countdown_in = countdown_ff;
      sample_in    = sample_ff;
      result       = '0;
      chan_wr      = '0;
      cs_tick      = control_ff;

      case (action)
         ACT_WRITE: begin
            if (bus_address == control_addr_ff) begin
               control_in = write_data;
               control_in[BIT_START] = control_ff[BIT_START] | write_data[BIT_START];
               // flag is write-one-to-clear
               control_in[BIT_FLAG] = write_data[BIT_FLAG] ? 1'b0 : control_ff[BIT_FLAG];
               if (write_data[BIT_START] && !control_ff[BIT_START] && write_data[BIT_ENABLE]) begin
                  countdown_in = CONV_CYCLES << prescale;
               end else if (!write_data[BIT_ENABLE]) begin
                  countdown_in = '0;
               end
            end else if (bus_address == mux_addr_ff) begin
               mux_in = write_data;
            end
         end
         ACT_READ: begin
            if (bus_address == high_addr_ff) begin
               result.read_data = adjusted[15:8];
            end else if (bus_address == low_addr_ff) begin
               result.read_data = adjusted[7:0];
            end else if (bus_address == control_addr_ff) begin
               result.read_data = control_ff;
            end else if (bus_address == mux_addr_ff) begin
               result.read_data = mux_ff;
            end
         end
         ACT_SAMPLE: begin
            chan_wr.en   = fire && (channel < NUM_CH);
            chan_wr.idx  = channel[CH_SEL_W-1:0];
            chan_wr.data = sample_value;
         end
         ACT_TICK: begin
            if (control_ff[BIT_ENABLE] && control_ff[BIT_START]) begin
               if (countdown_ff < CD_W'(cycles)) begin
                  countdown_in       = '0;
                  cs_tick[BIT_START] = 1'b0;
                  cs_tick[BIT_FLAG]  = 1'b1;
                  sample_in          = chan_rd;
               end else begin
                  countdown_in = countdown_ff - CD_W'(cycles);
               end
               control_in = cs_tick;
               if (cs_tick[BIT_IRQ_EN] && cs_tick[BIT_FLAG]) begin
                  result.irq_request = 1'b1;
                  result.irq_vector  = irq_vector_ff;
                  if (interrupt_accept) begin
                     control_in[BIT_FLAG] = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

endmodule

// File: rtl/adc_peripheral_registers_unit.sv
// Top level of the converter register block: request handshake and response register.
// Depends on apr_pkg and apr_ctrl (which holds apr_channels).
//
// Each request is a bus write, a bus read, a channel value update or a clock
// tick, and gives exactly one response (read data, interrupt request and
// vector). A request is taken every cycle while the response register is
// free or being emptied in the same cycle; its response appears on the next
// cycle. Sustained rate is one request per clock; the only limit is the
// single response register, so req_stall follows rsp_stall while a response
// is held. All state (control/status, channel select, countdown, latched
// result and the channel value bank) updates at the edge where a request is
// taken, so back-to-back requests always see the effect of the previous one.
// The address map and interrupt vector are set through the csr_ port; write
// it only while no request is in flight.
module adc_peripheral_registers_unit #(
   parameter int NUM_CHANNELS    = apr_pkg::NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS     = apr_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_TICK_CYCLES = apr_pkg::MAX_TICK_CYCLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [apr_pkg::ADDR_W-1:0]        req_bus_address,
   input  logic [apr_pkg::DATA_W-1:0]        req_write_data,
   input  logic [apr_pkg::CHAN_W-1:0]        req_channel,
   input  logic [apr_pkg::SAMPLE_W-1:0]      req_sample_value,
   input  logic [apr_pkg::TICK_W-1:0]        req_tick_cycles,
   input  logic                              req_interrupt_accept,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [apr_pkg::DATA_W-1:0]        rsp_read_data,
   output logic                              rsp_irq_request,
   output logic [apr_pkg::VEC_W-1:0]         rsp_irq_vector,
   // configuration
   input  logic                              csr_write_en,
   input  logic [apr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [apr_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import apr_pkg::*;

   logic    fire;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_result;

   // take a request unless a held response is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign fire      = req_valid & ~req_stall;

   apr_ctrl #(
      .NUM_CHANNELS   (NUM_CHANNELS),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .MAX_TICK_CYCLES(MAX_TICK_CYCLES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .action          (req_action),
      .bus_address     (req_bus_address),
      .write_data      (req_write_data),
      .channel         (req_channel),
      .sample_value    (req_sample_value),
      .tick_cycles     (req_tick_cycles),
      .interrupt_accept(req_interrupt_accept),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .result          (rsp_result)
   );

   // response held until taken; a new one loads when a request fires
   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_irq_request = rsp_ff.irq_request;
   assign rsp_irq_vector  = rsp_ff.irq_vector;

endmodule
